// ===== hw/rtl/affine_vertex_transform_centroid_top_macros.svh =====
// assertion macros for the affine vertex transform block
`ifndef AFFINE_VERTEX_TRANSFORM_CENTROID_TOP_MACROS_SVH
`define AFFINE_VERTEX_TRANSFORM_CENTROID_TOP_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define AVTC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define AVTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/avtc_pkg.sv =====
// shared types, constants and saturation helper for the affine vertex transform
package avtc_pkg;

   localparam int WORD_W      = 32;
   localparam int COEF_W      = 16;
   localparam int PROD_W      = WORD_W + COEF_W;
   localparam int ROT_SHIFT   = 14;
   localparam int SCALE_SHIFT = 8;
   localparam int ROT_W       = PROD_W - ROT_SHIFT;
   localparam int CSR_INDEX_W = 3;

   localparam logic signed [PROD_W-1:0] WIDE_HI = PROD_W'(64'sd2147483647);
   localparam logic signed [PROD_W-1:0] WIDE_LO = PROD_W'(-64'sd2147483648);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_COS_ROTATION = 3'd0,
      REG_SIN_ROTATION = 3'd1,
      REG_SCALE_X      = 3'd2,
      REG_SCALE_Y      = 3'd3,
      REG_OFFSET_X     = 3'd4,
      REG_OFFSET_Y     = 3'd5
   } csr_index_type;

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
      logic signed [WORD_W-1:0] r;
      if (v > WIDE_HI) begin
         r = WIDE_HI[WORD_W-1:0];
      end else if (v < WIDE_LO) begin
         r = WIDE_LO[WORD_W-1:0];
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/affine_vertex_transform_centroid_top.sv =====
// 2d rotate, scale and translate of polygon vertices with centroid on the last vertex
// ordinary vertex: six products issued one per cycle on the single shared 32x16 multiplier,
//   then the y offset in the tail and the sum into the polygon accumulators
// last vertex: two restoring divisions of sum x then sum y by the vertex count, on the shared divider
// one item at a time: req_tready low from accept until the result is taken
// reset: synchronous active high, registers return to identity transform, sums cleared
`include "affine_vertex_transform_centroid_top_macros.svh"

module affine_vertex_transform_centroid_top
   import avtc_pkg::*;
#(
   parameter int MAX_VERTICES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   // vertex input
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [2*WORD_W-1:0]    req_tdata,   // vertex_x, vertex_y
   input  logic                   req_tlast,   // last_vertex
   // result output
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [4*WORD_W-1:0]    rsp_tdata,   // world_x, world_y, center_x, center_y
   output logic                   rsp_tlast,   // center_valid
   output logic                   rsp_tuser,   // center_overflow
   // register writes, taken only while idle
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_data
);

   // sum of up to MAX_VERTICES signed words
   localparam int SUM_W  = WORD_W + $clog2(MAX_VERTICES);
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int DCNT_W = $clog2(SUM_W);
   localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_VERTICES);
   localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(SUM_W - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_TAIL,
      S_ACC,
      S_DLOAD,
      S_DSTEP,
      S_DSTORE,
      S_OUT
   } state_type;

   // which product the shared multiplier forms this cycle
   typedef enum logic [2:0] {
      P_XCOS,
      P_YSIN,
      P_XSIN,
      P_YCOS,
      P_RXSX,
      P_RYSY
   } step_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;

   // configuration registers
   logic signed [COEF_W-1:0] cos_ff, cos_in;
   logic signed [COEF_W-1:0] sin_ff, sin_in;
   logic signed [COEF_W-1:0] scx_ff, scx_in;
   logic signed [COEF_W-1:0] scy_ff, scy_in;
   logic signed [WORD_W-1:0] offx_ff, offx_in;
   logic signed [WORD_W-1:0] offy_ff, offy_in;

   // captured item
   logic signed [WORD_W-1:0] vx_ff, vx_in;
   logic signed [WORD_W-1:0] vy_ff, vy_in;
   logic                     last_ff, last_in;

   // datapath
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ROT_W-1:0]  rterm_ff, rterm_in;
   logic signed [WORD_W-1:0] rx_ff, rx_in;
   logic signed [WORD_W-1:0] ry_ff, ry_in;

   // polygon accumulators
   logic signed [SUM_W-1:0] sumx_ff, sumx_in;
   logic signed [SUM_W-1:0] sumy_ff, sumy_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    ovf_ff, ovf_in;

   // shared restoring divider
   logic [SUM_W-1:0]  dq_ff, dq_in;
   logic [CNT_W-1:0]  drem_ff, drem_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic              dneg_ff, dneg_in;
   logic              daxis_ff, daxis_in;

   // result registers
   logic signed [WORD_W-1:0] wx_ff, wx_in;
   logic signed [WORD_W-1:0] wy_ff, wy_in;
   logic signed [WORD_W-1:0] cx_ff, cx_in;
   logic signed [WORD_W-1:0] cy_ff, cy_in;
   logic                     cvalid_ff, cvalid_in;
   logic                     covf_ff, covf_in;

   // combinational helpers
   logic signed [WORD_W-1:0] mul_a;
   logic signed [COEF_W-1:0] mul_b;
   logic signed [PROD_W-1:0] rot_term;
   logic signed [PROD_W-1:0] scaled;
   logic signed [WORD_W-1:0] scaled_sat;
   logic signed [WORD_W-1:0] off_sel;
   logic signed [WORD_W-1:0] world_sat;
   logic signed [SUM_W-1:0]  div_src;
   logic [CNT_W:0]           rem_shift;
   logic                     rem_ge;
   logic [WORD_W-1:0]        quot_mag;
   logic [WORD_W-1:0]        quot_signed;

   // a pending register write goes ahead of a new item
   assign req_tready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {cy_ff, cx_ff, wy_ff, wx_ff};
   assign rsp_tlast  = cvalid_ff;
   assign rsp_tuser  = covf_ff;

   // shared multiplier operand select
   always_comb begin
      unique case (step_ff)
         P_XCOS:  begin mul_a = vx_ff; mul_b = cos_ff; end
         P_YSIN:  begin mul_a = vy_ff; mul_b = sin_ff; end
         P_XSIN:  begin mul_a = vx_ff; mul_b = sin_ff; end
         P_YCOS:  begin mul_a = vy_ff; mul_b = cos_ff; end
         P_RXSX:  begin mul_a = rx_ff; mul_b = scx_ff; end
         P_RYSY:  begin mul_a = ry_ff; mul_b = scy_ff; end
         default: begin mul_a = vx_ff; mul_b = cos_ff; end
      endcase
   end

   // floor shifts of the registered product
   assign rot_term   = prod_ff >>> ROT_SHIFT;
   assign scaled     = prod_ff >>> SCALE_SHIFT;
   assign scaled_sat = sat_word(scaled);
   // x offset while the x scale product is consumed, y offset in the tail
   assign off_sel    = (state_ff == S_TAIL) ? offy_ff : offx_ff;
   assign world_sat  = sat_word(PROD_W'(scaled_sat) + PROD_W'(off_sel));

   // divider step: shift in next dividend bit, subtract count when it fits
   assign div_src     = daxis_ff ? sumy_ff : sumx_ff;
   assign rem_shift   = {drem_ff, dq_ff[SUM_W-1]};
   assign rem_ge      = (rem_shift >= {1'b0, count_ff});
   // quotient magnitude is at most 2^31, so the low word holds it
   assign quot_mag    = dq_ff[WORD_W-1:0];
   assign quot_signed = dneg_ff ? (~quot_mag + 1'b1) : quot_mag;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cos_in    = cos_ff;
      sin_in    = sin_ff;
      scx_in    = scx_ff;
      scy_in    = scy_ff;
      offx_in   = offx_ff;
      offy_in   = offy_ff;
      vx_in     = vx_ff;
      vy_in     = vy_ff;
      last_in   = last_ff;
      prod_in   = prod_ff;
      rterm_in  = rterm_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      sumx_in   = sumx_ff;
      sumy_in   = sumy_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      dq_in     = dq_ff;
      drem_in   = drem_ff;
      dcnt_in   = dcnt_ff;
      dneg_in   = dneg_ff;
      daxis_in  = daxis_ff;
      wx_in     = wx_ff;
      wy_in     = wy_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      cvalid_in = cvalid_ff;
      covf_in   = covf_ff;

      // register writes, only taken while idle
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_COS_ROTATION: cos_in  = csr_data[COEF_W-1:0];
            REG_SIN_ROTATION: sin_in  = csr_data[COEF_W-1:0];
            REG_SCALE_X:      scx_in  = csr_data[COEF_W-1:0];
            REG_SCALE_Y:      scy_in  = csr_data[COEF_W-1:0];
            REG_OFFSET_X:     offx_in = csr_data;
            REG_OFFSET_Y:     offy_in = csr_data;
            default:          ;  // unknown index ignored
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               vx_in    = req_tdata[WORD_W-1:0];
               vy_in    = req_tdata[2*WORD_W-1:WORD_W];
               last_in  = req_tlast;
               step_in  = P_XCOS;
               state_in = S_MUL;
            end
         end

         S_MUL: begin
            prod_in = mul_a * mul_b;
            // consume the product issued last cycle
            unique case (step_ff)
               P_XCOS:  ;
               P_YSIN:  rterm_in = rot_term[ROT_W-1:0];
               P_XSIN:  rx_in = sat_word(PROD_W'(rterm_ff) - rot_term);
               P_YCOS:  rterm_in = rot_term[ROT_W-1:0];
               P_RXSX:  ry_in = sat_word(PROD_W'(rterm_ff) + rot_term);
               P_RYSY:  wx_in = world_sat;
               default: ;
            endcase
            if (step_ff == P_RYSY) begin
               state_in = S_TAIL;
            end else begin
               step_in = step_type'(step_ff + 3'd1);
            end
         end

         S_TAIL: begin
            wy_in    = world_sat;
            state_in = S_ACC;
         end

         S_ACC: begin
            if (count_ff < CNT_MAX) begin
               sumx_in  = sumx_ff + SUM_W'(wx_ff);
               sumy_in  = sumy_ff + SUM_W'(wy_ff);
               count_in = count_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
            cx_in     = '0;
            cy_in     = '0;
            cvalid_in = 1'b0;
            covf_in   = 1'b0;
            daxis_in  = 1'b0;
            state_in  = last_ff ? S_DLOAD : S_OUT;
         end

         S_DLOAD: begin
            dneg_in  = div_src[SUM_W-1];
            dq_in    = div_src[SUM_W-1] ? -div_src : div_src;
            drem_in  = '0;
            dcnt_in  = DCNT_LAST;
            state_in = S_DSTEP;
         end

         S_DSTEP: begin
            drem_in = rem_ge ? CNT_W'(rem_shift - {1'b0, count_ff}) : rem_shift[CNT_W-1:0];
            dq_in   = {dq_ff[SUM_W-2:0], rem_ge};
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == '0) begin
               state_in = S_DSTORE;
            end
         end

         S_DSTORE: begin
            if (!daxis_ff) begin
               cx_in    = quot_signed;
               daxis_in = 1'b1;
               state_in = S_DLOAD;
            end else begin
               cy_in     = quot_signed;
               cvalid_in = 1'b1;
               covf_in   = ovf_ff;
               // polygon done, start the next one fresh
               sumx_in   = '0;
               sumy_in   = '0;
               count_in  = '0;
               ovf_in    = 1'b0;
               state_in  = S_OUT;
            end
         end

         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         step_ff   <= P_XCOS;
         cos_ff    <= 16'sd16384;
         sin_ff    <= '0;
         scx_ff    <= 16'sd256;
         scy_ff    <= 16'sd256;
         offx_ff   <= '0;
         offy_ff   <= '0;
         sumx_ff   <= '0;
         sumy_ff   <= '0;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         daxis_ff  <= 1'b0;
         cvalid_ff <= 1'b0;
         covf_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         cos_ff    <= cos_in;
         sin_ff    <= sin_in;
         scx_ff    <= scx_in;
         scy_ff    <= scy_in;
         offx_ff   <= offx_in;
         offy_ff   <= offy_in;
         sumx_ff   <= sumx_in;
         sumy_ff   <= sumy_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         daxis_ff  <= daxis_in;
         cvalid_ff <= cvalid_in;
         covf_ff   <= covf_in;
      end
      vx_ff    <= vx_in;
      vy_ff    <= vy_in;
      last_ff  <= last_in;
      prod_ff  <= prod_in;
      rterm_ff <= rterm_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      dq_ff    <= dq_in;
      drem_ff  <= drem_in;
      dcnt_ff  <= dcnt_in;
      dneg_ff  <= dneg_in;
      wx_ff    <= wx_in;
      wy_ff    <= wy_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
   end

   `AVTC_ASSERT_NOW(a_no_accept_with_result, req_tready, !rsp_tvalid, "ready while result pending")
   `AVTC_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "ready after accept")
   `AVTC_ASSERT_NOW(a_center_zero, rsp_tvalid && !rsp_tlast, (rsp_tdata[4*WORD_W-1:2*WORD_W] == '0) && !rsp_tuser, "centroid fields set on non-last item")
   `AVTC_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_MAX, "vertex count beyond limit")
   `AVTC_ASSERT_NOW(a_ovf_full, ovf_ff, count_ff == CNT_MAX, "overflow with count not full")

endmodule
